FILE: hw/rtl/grq_pkg.sv
// package for the graph reachability query block
// shared widths, command and result codes, memory control struct; no dependencies
package grq_pkg;

  // field widths
  localparam int CMD_W  = 2;
  localparam int VTX_W  = 6;
  localparam int KIND_W = 2;
  localparam int VAL_W  = 7;
  localparam int CNT_W  = 7;

  // default graph size and register reset value
  localparam int DEF_MAX_VERTICES = 64;
  localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = 7'd64;

  // input commands
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_COUNT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VERTEX = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

  // adjacency memory control
  typedef struct packed {
    logic wr_en;
    logic clr_all;
  } grq_mem_ctl_t;

endpackage

FILE: hw/rtl/grq_ffs.sv
// lowest set bit finder shared by frontier expansion and result listing
// depends on nothing but its parameters
module grq_ffs #(
  parameter int W     = 64,
  parameter int IDX_W = 6
) (
  input  logic [W-1:0]     vec,
  output logic [IDX_W-1:0] idx,
  output logic             any
);

  // priority select, lowest index wins
  always_comb begin
    idx = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = IDX_W'(i);
      end
    end
  end

  assign any = |vec;

endmodule

FILE: hw/rtl/grq_adj_mem.sv
// adjacency bit matrix: one row per origin vertex, registered read
// depends on grq_pkg; per-row valid bits give the all-zero reset and clear
module grq_adj_mem
  import grq_pkg::*;
#(
  parameter int W     = 64,
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  grq_mem_ctl_t     ctl,
  input  logic [IDX_W-1:0] waddr,
  input  logic [W-1:0]     wdata,
  input  logic [IDX_W-1:0] raddr,
  output logic [W-1:0]     rdata
);

  logic [W-1:0] mem [W];
  logic [W-1:0] vld_r;
  logic [W-1:0] rd_data_r;
  logic         rd_vld_r;

  // row storage
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  // row valid bits, cleared by reset and by a clear command
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr_all) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        vld_r[waddr] <= 1'b1;
      end
      rd_vld_r <= vld_r[raddr];
    end
  end

  // a row never written reads as empty
  assign rdata = rd_vld_r ? rd_data_r : '0;

endmodule

FILE: hw/rtl/graph_reachability_query_top.sv
// graph reachability query engine, top level with sequencer
// an add reads the origin row, then writes it back; clear and unused commands end in
//   idle; an error sends one result; a query reads and merges the row of each reached
//   vertex in turn, then sends the count and each unreached vertex as its own result
// one transaction at a time: in_stall is high until the sequencer is back in idle
// synchronous active-low reset: empty graph, vertex_count 64, no result pending
module graph_reachability_query_top
  import grq_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [VTX_W-1:0]  in_first_vertex,
  input  logic [VTX_W-1:0]  in_second_vertex,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KIND_W-1:0] out_kind,
  output logic [VAL_W-1:0]  out_value,
  output logic              out_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_vertex_count
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_VERTICES);
  localparam logic [MAX_VERTICES-1:0] ONE = MAX_VERTICES'(1);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ADD_RD = 3'd1;
  localparam logic [2:0] ST_ADD_WR = 3'd2;
  localparam logic [2:0] ST_PICK   = 3'd3;
  localparam logic [2:0] ST_MERGE  = 3'd4;
  localparam logic [2:0] ST_COUNT  = 3'd5;
  localparam logic [2:0] ST_LIST   = 3'd6;
  localparam logic [2:0] ST_ERR    = 3'd7;

  logic [2:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        vcount_r;
  logic [VTX_W-1:0]        a_r, a_nxt;
  logic [VTX_W-1:0]        b_r, b_nxt;
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic [MAX_VERTICES-1:0] frontier_r, frontier_nxt;
  logic [CNT_W-1:0]        pops_r, pops_nxt;
  logic [CNT_W-1:0]        rem_r, rem_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]       out_kind_r, out_kind_nxt;
  logic [VAL_W-1:0]        out_value_r, out_value_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [CNT_W-1:0]        n_w;
  logic [MAX_VERTICES-1:0] use_mask;
  logic [MAX_VERTICES-1:0] row;
  logic [MAX_VERTICES-1:0] fresh;
  logic [IDX_W-1:0]        ffs_idx;
  logic                    ffs_any;
  logic [IDX_W-1:0]        raddr;
  logic [CNT_W-1:0]        unreached;
  logic                    in_acc;
  logic                    out_free;
  grq_mem_ctl_t            mem_ctl;

  // vertices in use and their mask
  assign n_w = (vcount_r > MAX_N) ? MAX_N : vcount_r;

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      use_mask[i] = (CNT_W'(i) < n_w);
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign fresh     = row & use_mask & ~visited_r;
  assign unreached = n_w - pops_r;

  // shared bit finder over the frontier or the unreached list
  grq_ffs #(
    .W     (MAX_VERTICES),
    .IDX_W (IDX_W)
  ) u_ffs (
    .vec (frontier_r),
    .idx (ffs_idx),
    .any (ffs_any)
  );

  assign raddr = (state_r == ST_ADD_RD) ? a_r[IDX_W-1:0] : ffs_idx;

  grq_adj_mem #(
    .W     (MAX_VERTICES),
    .IDX_W (IDX_W)
  ) u_adj_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mem_ctl),
    .waddr (a_r[IDX_W-1:0]),
    .wdata (row | (ONE << b_r[IDX_W-1:0])),
    .raddr (raddr),
    .rdata (row)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    visited_nxt   = visited_r;
    frontier_nxt  = frontier_r;
    pops_nxt      = pops_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    mem_ctl       = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          a_nxt = in_first_vertex;
          b_nxt = in_second_vertex;
          case (in_cmd)
            CMD_ADD: begin
              if ({1'b0, in_first_vertex} >= n_w) begin
                state_nxt = ST_ERR;
              end else if ({1'b0, in_second_vertex} >= n_w) begin
                a_nxt     = in_second_vertex;
                state_nxt = ST_ERR;
              end else begin
                state_nxt = ST_ADD_RD;
              end
            end
            CMD_QUERY: begin
              if ({1'b0, in_first_vertex} >= n_w) begin
                state_nxt = ST_ERR;
              end else begin
                visited_nxt  = ONE << in_first_vertex[IDX_W-1:0];
                frontier_nxt = ONE << in_first_vertex[IDX_W-1:0];
                pops_nxt     = '0;
                state_nxt    = ST_PICK;
              end
            end
            CMD_CLEAR: begin
              mem_ctl.clr_all = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADD_RD: begin
        state_nxt = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        mem_ctl.wr_en = 1'b1;
        state_nxt     = ST_IDLE;
      end
      // take the lowest frontier vertex and read its row
      ST_PICK: begin
        if (ffs_any) begin
          frontier_nxt = frontier_r & ~(ONE << ffs_idx);
          pops_nxt     = pops_r + 1'b1;
          state_nxt    = ST_MERGE;
        end else begin
          state_nxt = ST_COUNT;
        end
      end
      // newly reached vertices join the frontier
      ST_MERGE: begin
        visited_nxt  = visited_r | fresh;
        frontier_nxt = frontier_r | fresh;
        state_nxt    = ST_PICK;
      end
      ST_COUNT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_COUNT;
          out_value_nxt = unreached;
          out_last_nxt  = (unreached == '0);
          rem_nxt       = unreached;
          frontier_nxt  = use_mask & ~visited_r;
          state_nxt     = (unreached == '0) ? ST_IDLE : ST_LIST;
        end
      end
      // unreached vertices in ascending order
      ST_LIST: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_VERTEX;
          out_value_nxt = {{(VAL_W - IDX_W){1'b0}}, ffs_idx};
          out_last_nxt  = (rem_r == CNT_W'(1));
          frontier_nxt  = frontier_r & ~(ONE << ffs_idx);
          rem_nxt       = rem_r - 1'b1;
          if (rem_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_ERROR;
          out_value_nxt = {1'b0, a_r};
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vcount_r    <= VERTEX_COUNT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        vcount_r <= cfg_vertex_count;
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    visited_r   <= visited_nxt;
    frontier_r  <= frontier_nxt;
    pops_r      <= pops_nxt;
    rem_r       <= rem_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule

FILE: hw/rtl/grq_checker.sv
// port-level checks for the graph reachability query top level
// depends on grq_pkg; bound to graph_reachability_query_top below
module grq_checker
  import grq_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [CMD_W-1:0]  in_cmd,
  input logic              out_valid,
  input logic              out_stall,
  input logic [KIND_W-1:0] out_kind,
  input logic [VAL_W-1:0]  out_value,
  input logic              out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_value)
      && $stable(out_last))
    else $error("stalled result changed");

  // reset leaves no result pending
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // an error is always the only result of its transaction
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ERROR |-> out_last)
    else $error("error result without last");

  // listed vertices lie below MAX_VERTICES
  a_vtx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_VERTEX |-> out_value < VAL_W'(MAX_VERTICES))
    else $error("listed vertex out of range");

  // a query keeps the input side busy on the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_cmd == CMD_QUERY |=> in_stall)
    else $error("query accepted without going busy");

endmodule

bind graph_reachability_query_top grq_checker #(
  .MAX_VERTICES (MAX_VERTICES)
) u_grq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_cmd    (in_cmd),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_kind  (out_kind),
  .out_value (out_value),
  .out_last  (out_last)
);
